### sv/mmh_pkg.sv
// package: constants, microcode control word and program table of the murmur64a hash engine
package mmh_pkg;

  localparam logic [63:0] MixMult  = 64'hc6a4a7935bd1e995;
  localparam int unsigned MixShift = 47;
  localparam logic [63:0] SeedReset = 64'd76493;

  localparam int unsigned PcWidth = 5;

  // program labels
  localparam logic [PcWidth-1:0] PcIdle     = 5'd0;
  localparam logic [PcWidth-1:0] PcDispatch = 5'd6;
  localparam logic [PcWidth-1:0] PcMulHash  = 5'd17;
  localparam logic [PcWidth-1:0] PcLastChk  = 5'd21;

  // multiplier operand register source
  typedef enum logic [2:0] {
    X_HOLD,
    X_LEN,
    X_WORD,
    X_TAIL,
    X_ACC_XS,
    X_H_XOR_ACC,
    X_H_XS
  } x_sel_e;

  // one partial product pass of the 64x64 low-half multiply by the constant
  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_LO,
    MUL_X1,
    MUL_X2
  } mul_op_e;

  typedef enum logic [1:0] {
    H_HOLD,
    H_SEED_ACC,
    H_ACC
  } h_sel_e;

  typedef enum logic [2:0] {
    J_NEXT,
    J_WAIT_IN,
    J_NOT_FIRST,
    J_NO_BYTES,
    J_TAIL,
    J_NOT_LAST,
    J_EMIT
  } jump_e;

  typedef struct packed {
    x_sel_e              x_sel;
    mul_op_e             mul_op;
    h_sel_e              h_sel;
    jump_e               jump;
    logic [PcWidth-1:0]  target;
  } ctrl_t;

  function automatic ctrl_t uword(input x_sel_e x, input mul_op_e m, input h_sel_e h,
                                  input jump_e j, input logic [PcWidth-1:0] t);
    ctrl_t c;
    c.x_sel  = x;
    c.mul_op = m;
    c.h_sel  = h;
    c.jump   = j;
    c.target = t;
    return c;
  endfunction

  // program rom
  function automatic ctrl_t ucode(input logic [PcWidth-1:0] pc);
    ctrl_t c;
    case (pc)
      5'd0:  c = uword(X_HOLD,      MUL_NONE, H_HOLD,     J_WAIT_IN,   PcIdle);
      5'd1:  c = uword(X_LEN,       MUL_NONE, H_HOLD,     J_NOT_FIRST, PcDispatch);
      5'd2:  c = uword(X_HOLD,      MUL_LO,   H_HOLD,     J_NEXT,      PcIdle);
      5'd3:  c = uword(X_HOLD,      MUL_X1,   H_HOLD,     J_NEXT,      PcIdle);
      5'd4:  c = uword(X_HOLD,      MUL_X2,   H_HOLD,     J_NEXT,      PcIdle);
      5'd5:  c = uword(X_HOLD,      MUL_NONE, H_SEED_ACC, J_NEXT,      PcIdle);
      5'd6:  c = uword(X_HOLD,      MUL_NONE, H_HOLD,     J_NO_BYTES,  PcLastChk);
      5'd7:  c = uword(X_TAIL,      MUL_NONE, H_HOLD,     J_TAIL,      PcMulHash);
      5'd8:  c = uword(X_WORD,      MUL_NONE, H_HOLD,     J_NEXT,      PcIdle);
      5'd9:  c = uword(X_HOLD,      MUL_LO,   H_HOLD,     J_NEXT,      PcIdle);
      5'd10: c = uword(X_HOLD,      MUL_X1,   H_HOLD,     J_NEXT,      PcIdle);
      5'd11: c = uword(X_HOLD,      MUL_X2,   H_HOLD,     J_NEXT,      PcIdle);
      5'd12: c = uword(X_ACC_XS,    MUL_NONE, H_HOLD,     J_NEXT,      PcIdle);
      5'd13: c = uword(X_HOLD,      MUL_LO,   H_HOLD,     J_NEXT,      PcIdle);
      5'd14: c = uword(X_HOLD,      MUL_X1,   H_HOLD,     J_NEXT,      PcIdle);
      5'd15: c = uword(X_HOLD,      MUL_X2,   H_HOLD,     J_NEXT,      PcIdle);
      5'd16: c = uword(X_H_XOR_ACC, MUL_NONE, H_HOLD,     J_NEXT,      PcIdle);
      5'd17: c = uword(X_HOLD,      MUL_LO,   H_HOLD,     J_NEXT,      PcIdle);
      5'd18: c = uword(X_HOLD,      MUL_X1,   H_HOLD,     J_NEXT,      PcIdle);
      5'd19: c = uword(X_HOLD,      MUL_X2,   H_HOLD,     J_NEXT,      PcIdle);
      5'd20: c = uword(X_HOLD,      MUL_NONE, H_ACC,      J_NEXT,      PcIdle);
      5'd21: c = uword(X_H_XS,      MUL_NONE, H_HOLD,     J_NOT_LAST,  PcIdle);
      5'd22: c = uword(X_HOLD,      MUL_LO,   H_HOLD,     J_NEXT,      PcIdle);
      5'd23: c = uword(X_HOLD,      MUL_X1,   H_HOLD,     J_NEXT,      PcIdle);
      5'd24: c = uword(X_HOLD,      MUL_X2,   H_HOLD,     J_NEXT,      PcIdle);
      5'd25: c = uword(X_HOLD,      MUL_NONE, H_HOLD,     J_EMIT,      PcIdle);
      default: c = uword(X_HOLD,    MUL_NONE, H_HOLD,     J_NEXT,      PcIdle);
    endcase
    return c;
  endfunction

  // keep the low nb bytes of a word
  function automatic logic [63:0] byte_mask(input logic [2:0] nb);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (3'(i) < nb) begin
        m[i*8 +: 8] = 8'hff;
      end
    end
    return m;
  endfunction

  function automatic logic [63:0] xor_shift(input logic [63:0] v);
    return v ^ (v >> MixShift);
  endfunction

endpackage

### sv/mmh_mul.sv
// multiply unit: low 64 bits of operand times the mix constant, one 32x32 pass per step
module mmh_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mmh_pkg::mul_op_e  mul_op_i,
  input  logic [63:0]       x_i,
  output logic [63:0]       acc_o
);

  logic [63:0] acc_q, acc_d;
  logic [31:0] a_op, b_op;
  logic [63:0] prod;

  assign a_op = (mul_op_i == mmh_pkg::MUL_X1) ? x_i[63:32] : x_i[31:0];
  assign b_op = (mul_op_i == mmh_pkg::MUL_X2) ? mmh_pkg::MixMult[63:32]
                                               : mmh_pkg::MixMult[31:0];
  assign prod = 64'(a_op) * 64'(b_op);

  always_comb begin
    acc_d = acc_q;
    case (mul_op_i)
      mmh_pkg::MUL_LO: acc_d = prod;
      mmh_pkg::MUL_X1,
      mmh_pkg::MUL_X2: acc_d = {acc_q[63:32] + prod[31:0], acc_q[31:0]};
      default:         acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

### sv/murmur64a_hash_engine_unit.sv
// top level: microcoded murmurhash2 64a engine with seed register and output register
//
// usage
// - input channel: one transfer per 64-bit little-endian message word with its valid
//   byte count and first/last marks; total_length is taken on the first word only
// - a first word seeds the hash with hash_seed ^ (total_length * mix constant)
// - a word with 8 (or more) valid bytes is mixed in fully, 1 to 7 bytes as a masked tail,
//   zero bytes mixes nothing; a last word runs the final mix and produces one hash_value
// - hash_seed is written through cfg_we_i / cfg_wdata_i; the user keeps such writes to
//   times while the engine is idle, which the block itself does not enforce
// - one word at a time: a new word is taken only once the sequencer is back at idle
// - the pace is set by the one 32x32 multiplier: every 64-bit multiply by the
//   constant is three passes of it, stepped by the microcode rom
// - the result sits in an output register; a stalled result holds, and the engine keeps
//   taking words meanwhile; only the next final mix waits for the register to free up
// - reset: sequencer idle, output empty, running hash zero, hash_seed back to 76493
module murmur64a_hash_engine_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [63:0] cfg_wdata_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] data_word_i,
  input  logic [3:0]  valid_bytes_i,
  input  logic        first_word_i,
  input  logic        last_word_i,
  input  logic [30:0] total_length_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] hash_value_o
);

  localparam int unsigned PcW = mmh_pkg::PcWidth;

  // sequencer
  logic [PcW-1:0] pc_q, pc_d;
  mmh_pkg::ctrl_t ctrl;

  // configuration
  logic [63:0] seed_q;

  // latched item
  logic [63:0] word_q;
  logic [3:0]  nb_q;
  logic        first_q, last_q;
  logic [30:0] len_q;

  // datapath
  logic [63:0] x_q, x_d;
  logic [63:0] h_q, h_d;
  logic [63:0] acc;

  // result register
  logic        out_valid_q, out_valid_d;
  logic [63:0] out_hash_q, out_hash_d;

  logic in_xfer, out_xfer, emit;

  assign ctrl       = mmh_pkg::ucode(pc_q);
  assign in_stall_o = (pc_q != mmh_pkg::PcIdle);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_xfer   = out_valid_q && !out_stall_i;
  // final hash may be written once the result register is free or draining
  assign emit       = (ctrl.jump == mmh_pkg::J_EMIT) && (!out_valid_q || !out_stall_i);

  mmh_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .mul_op_i (ctrl.mul_op),
    .x_i      (x_q),
    .acc_o    (acc)
  );

  // next step: fall through or take the conditional jump
  always_comb begin
    pc_d = pc_q + PcW'(1);
    case (ctrl.jump)
      mmh_pkg::J_NEXT:      pc_d = pc_q + PcW'(1);
      mmh_pkg::J_WAIT_IN:   pc_d = in_xfer ? pc_q + PcW'(1) : pc_q;
      mmh_pkg::J_NOT_FIRST: pc_d = !first_q ? ctrl.target : pc_q + PcW'(1);
      mmh_pkg::J_NO_BYTES:  pc_d = (nb_q == 4'd0) ? ctrl.target : pc_q + PcW'(1);
      // nonzero count below eight is a tail; counts of eight and up are full words
      mmh_pkg::J_TAIL:      pc_d = !nb_q[3] ? ctrl.target : pc_q + PcW'(1);
      mmh_pkg::J_NOT_LAST:  pc_d = !last_q ? ctrl.target : pc_q + PcW'(1);
      mmh_pkg::J_EMIT:      pc_d = emit ? ctrl.target : pc_q;
      default:              pc_d = mmh_pkg::PcIdle;
    endcase
  end

  // multiplier operand
  always_comb begin
    x_d = x_q;
    case (ctrl.x_sel)
      mmh_pkg::X_HOLD:      x_d = x_q;
      mmh_pkg::X_LEN:       x_d = {33'd0, len_q};
      mmh_pkg::X_WORD:      x_d = word_q;
      mmh_pkg::X_TAIL:      x_d = h_q ^ (word_q & mmh_pkg::byte_mask(nb_q[2:0]));
      mmh_pkg::X_ACC_XS:    x_d = mmh_pkg::xor_shift(acc);
      mmh_pkg::X_H_XOR_ACC: x_d = h_q ^ acc;
      mmh_pkg::X_H_XS:      x_d = mmh_pkg::xor_shift(h_q);
      default:              x_d = x_q;
    endcase
  end

  // running hash
  always_comb begin
    h_d = h_q;
    case (ctrl.h_sel)
      mmh_pkg::H_SEED_ACC: h_d = seed_q ^ acc;
      mmh_pkg::H_ACC:      h_d = acc;
      default:             h_d = h_q;
    endcase
  end

  // result register: filled by the final mix, cleared on transfer
  always_comb begin
    out_valid_d = out_valid_q;
    out_hash_d  = out_hash_q;
    if (out_xfer) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
      out_hash_d  = mmh_pkg::xor_shift(acc);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= mmh_pkg::PcIdle;
      seed_q      <= mmh_pkg::SeedReset;
      h_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      h_q         <= h_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        seed_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    out_hash_q <= out_hash_d;
    if (in_xfer) begin
      word_q  <= data_word_i;
      nb_q    <= valid_bytes_i;
      first_q <= first_word_i;
      last_q  <= last_word_i;
      len_q   <= total_length_i;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hash_value_o = out_hash_q;

endmodule

### dv/mmh_digest_monitor.sv
// monitor for the murmur64a hash engine: tracks seed and running hash, predicts and compares digests
`timescale 1ns / 100ps

module mmh_digest_monitor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [63:0] data_word_i,
  input  logic [3:0]  valid_bytes_i,
  input  logic        first_word_i,
  input  logic        last_word_i,
  input  logic [30:0] total_length_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [63:0] hash_value_i,
  output int          pending_o,
  output int          fail_count_o
);

  logic [63:0] seed_q;
  logic [63:0] run_hash;
  logic [63:0] digest_q[$];
  int          mismatch_cnt = 0;
  int          digests_seen = 0;

  // absorb one message word into the running hash
  function automatic logic [63:0] fold_word(input logic [63:0] acc, input logic [63:0] word,
                                            input logic [3:0] nbytes);
    logic [63:0] k;
    logic [63:0] keep;
    if (nbytes[3]) begin
      k   = word * mmh_pkg::MixMult;
      k   = k ^ (k >> mmh_pkg::MixShift);
      k   = k * mmh_pkg::MixMult;
      acc = (acc ^ k) * mmh_pkg::MixMult;
    end else if (nbytes != 4'd0) begin
      keep = ~(64'hffff_ffff_ffff_ffff << {nbytes, 3'b000});
      acc  = (acc ^ (word & keep)) * mmh_pkg::MixMult;
    end
    return acc;
  endfunction

  function automatic logic [63:0] finish_digest(input logic [63:0] acc);
    acc = acc ^ (acc >> mmh_pkg::MixShift);
    acc = acc * mmh_pkg::MixMult;
    acc = acc ^ (acc >> mmh_pkg::MixShift);
    return acc;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatch_cnt++;
    $display("mismatch at %0t ns: %s", $realtime, what);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic [63:0] want;
    if (!rst_ni) begin
      seed_q   = mmh_pkg::SeedReset;
      run_hash = '0;
      digest_q.delete();
      pending_o    <= 0;
      fail_count_o <= mismatch_cnt;
    end else begin
      // result side first: a digest never leaves on the edge its last word enters
      if (out_valid_i && !out_stall_i) begin
        digests_seen++;
        if (digest_q.size() == 0) begin
          flag_mismatch($sformatf("digest %0d: hash %h with no message pending",
                                  digests_seen, hash_value_i));
        end else begin
          want = digest_q.pop_front();
          if (hash_value_i !== want) begin
            flag_mismatch($sformatf("digest %0d: hash_value %h, predicted %h",
                                    digests_seen, hash_value_i, want));
          end
        end
      end
      if (cfg_we_i) begin
        seed_q = cfg_wdata_i;
      end
      if (in_valid_i && !in_stall_i) begin
        if (first_word_i) begin
          run_hash = seed_q ^ ({33'd0, total_length_i} * mmh_pkg::MixMult);
        end
        run_hash = fold_word(run_hash, data_word_i, valid_bytes_i);
        if (last_word_i) begin
          digest_q.push_back(finish_digest(run_hash));
        end
      end
      pending_o    <= digest_q.size();
      fail_count_o <= mismatch_cnt;
    end
  end

endmodule

### dv/murmur64a_hash_engine_unit_test.sv
// testbench top: stimulus, idling and verdict for the murmur64a hash engine
`timescale 1ns / 100ps

module murmur64a_hash_engine_unit_test;

  // generous ceiling: ~1.7k words, each at worst a long gap, a full pass of the engine
  // microcode and a long output stall, taken several times over
  localparam int unsigned CycleLimit = 700_000;
  // idle cycles after the last digest before touching hash_seed or ending the run
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned PhaseWords = 320;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        cfg_we_i       = 1'b0;
  logic [63:0] cfg_wdata_i    = '0;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  logic [63:0] data_word_i    = '0;
  logic [3:0]  valid_bytes_i  = '0;
  logic        first_word_i   = 1'b0;
  logic        last_word_i    = 1'b0;
  logic [30:0] total_length_i = '0;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  logic [63:0] hash_value_o;

  int          pending;
  int          fail_count;
  int unsigned cycle_cnt   = 0;
  int unsigned words_sent  = 0;
  bit          quiet_in    = 1'b0;

  // 50 MHz clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  murmur64a_hash_engine_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_word_i    (data_word_i),
    .valid_bytes_i  (valid_bytes_i),
    .first_word_i   (first_word_i),
    .last_word_i    (last_word_i),
    .total_length_i (total_length_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .hash_value_o   (hash_value_o)
  );

  // watches both channels and the seed port, predicts every digest
  mmh_digest_monitor u_monitor (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .data_word_i    (data_word_i),
    .valid_bytes_i  (valid_bytes_i),
    .first_word_i   (first_word_i),
    .last_word_i    (last_word_i),
    .total_length_i (total_length_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .hash_value_i   (hash_value_o),
    .pending_o      (pending),
    .fail_count_o   (fail_count)
  );

  // watchdog: a hung handshake ends the run here
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver back-pressure: stretches of calm alternate with random stalls,
  // now and then a long one
  int unsigned span_left  = 0;
  int unsigned stall_left = 0;
  bit          calm_span  = 1'b0;

  always @(posedge clk_i) begin
    if (span_left == 0) begin
      span_left = $urandom_range(50, 300);
      calm_span = ($urandom_range(0, 3) == 0);
    end else begin
      span_left--;
    end
    if (stall_left != 0) begin
      stall_left--;
    end else if (!calm_span && $urandom_range(0, 99) < 30) begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 3);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  function automatic logic [63:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  // sender idle length: mostly none or short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // one transfer on the input channel; returns at the edge that took it
  task automatic send_word(input logic [63:0] data, input logic [3:0] nbytes,
                           input logic first, input logic last, input logic [30:0] len);
    int unsigned gap;
    gap = quiet_in ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    data_word_i    <= data;
    valid_bytes_i  <= nbytes;
    first_word_i   <= first;
    last_word_i    <= last;
    total_length_i <= len;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
    // every so often switch between a gap-free burst and normal idling
    if (words_sent % 64 == 0) begin
      quiet_in = ($urandom_range(0, 3) == 0);
    end
  endtask

  // well-formed message of msg_len bytes: full words, and a masked tail if bytes remain
  task automatic send_message(input int unsigned msg_len, input logic [30:0] len_field);
    int unsigned n_words;
    int unsigned left;
    n_words = (msg_len == 0) ? 1 : (msg_len + 7) / 8;
    left    = msg_len;
    for (int w = 0; w < n_words; w++) begin
      send_word(rand_word(), (left >= 8) ? 4'd8 : 4'(left), w == 0, w == n_words - 1,
                len_field);
      left = (left >= 8) ? left - 8 : 0;
    end
  endtask

  // let every digest out, then give the engine time to fall idle
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic load_seed(input logic [63:0] seed);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= seed;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // random traffic: mostly proper messages, some with a wrong length field,
  // the rest unframed noise words with any byte count and marks
  task automatic random_phase(input int unsigned n_items);
    int unsigned start;
    int unsigned r;
    int unsigned msg_len;
    logic [30:0] len_field;
    start = words_sent;
    while (words_sent - start < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        send_word(rand_word(), 4'($urandom_range(0, 15)), 1'($urandom()), 1'($urandom()),
                  31'($urandom()));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) msg_len = $urandom_range(0, 24);
        else if (r < 92) msg_len = $urandom_range(25, 96);
        else msg_len = $urandom_range(97, 300);
        len_field = ($urandom_range(0, 9) == 0) ? 31'($urandom()) : 31'(msg_len);
        send_message(msg_len, len_field);
      end
    end
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at the reset seed
    // continuation with no first word: mixing starts from the cleared running hash
    send_word(rand_word(), 4'd8, 1'b0, 1'b1, 31'd0);
    // empty message: seeded hash straight into the final mix
    send_word(64'd0, 4'd0, 1'b1, 1'b1, 31'd0);
    // single full words at the data and length extremes
    send_word(64'd0, 4'd8, 1'b1, 1'b1, 31'd8);
    send_word(64'hffff_ffff_ffff_ffff, 4'd8, 1'b1, 1'b1, 31'h7fff_ffff);
    // byte counts above eight behave as a full word
    send_word(rand_word(), 4'd15, 1'b1, 1'b1, 31'd8);
    send_word(rand_word(), 4'd9, 1'b1, 1'b1, 31'd8);
    // every tail size, all-ones data so masking of the upper bytes shows
    for (int nb = 1; nb < 8; nb++) begin
      send_word(64'hffff_ffff_ffff_ffff, 4'(nb), 1'b1, 1'b1, 31'(nb));
    end
    // short word in the middle of a message is folded in as a tail
    send_word(rand_word(), 4'd3, 1'b1, 1'b0, 31'd11);
    send_word(rand_word(), 4'd8, 1'b0, 1'b1, 31'd11);
    // zero-byte word that is not last mixes nothing
    send_word(rand_word(), 4'd0, 1'b1, 1'b0, 31'd5);
    send_word(rand_word(), 4'd5, 1'b0, 1'b1, 31'd5);
    // continuation right after a digest picks up the pre-finalize hash
    send_word(rand_word(), 4'd8, 1'b0, 1'b1, 31'd0);
    // three-word message ending in a six-byte tail
    send_message(22, 31'd22);
    // length field that disagrees with the bytes sent
    send_word(rand_word(), 4'd8, 1'b1, 1'b1, 31'h5555_5555);
    drain();

    // random phases across several seeds, extremes included
    load_seed(64'd0);
    random_phase(PhaseWords);
    load_seed(64'hffff_ffff_ffff_ffff);
    random_phase(PhaseWords);
    load_seed(rand_word());
    random_phase(PhaseWords);
    load_seed(mmh_pkg::SeedReset);
    random_phase(PhaseWords);
    load_seed(rand_word());
    random_phase(PhaseWords);

    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
